// File: hw/rtl/dcsoc_pkg.sv
// ----------------------------------------------------------------------------
// dcsoc_pkg
// Shared widths, constants, register codes and control types for the
// dual current-sense offset calibration block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dcsoc_pkg;

   localparam int RAW_W   = 12;
   localparam int FS_W    = 12;
   localparam int GAIN_W  = 8;
   localparam int MV_W    = 12;
   localparam int PROD_W  = RAW_W + FS_W;
   localparam int CUR_W   = 21;
   localparam int DIFF_W  = MV_W + 1;
   localparam int ACC_W   = 20;
   localparam int CNT_W   = 9;
   localparam int RECIP_W = ACC_W + 1;
   localparam int MEAN_W  = ACC_W + RECIP_W;

   localparam logic [FS_W-1:0]   FS_RESET   = 12'd3232;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd20;
   localparam logic [FS_W-1:0]   FULL_CODE  = 12'hFFF;

   // register index, taken from word address bit
   localparam logic REG_FULL_SCALE = 1'b0;
   localparam logic REG_GAIN       = 1'b1;

   typedef struct packed {
      logic accept;
      logic scale;
      logic update;
      logic take_mean;
      logic load_out;
   } dcsoc_cmd_type;

   typedef struct packed {
      logic cal_done;
      logic out_free;
   } dcsoc_status_type;

   // x / 4095 for x up to 4095*4095: x = 4095*q0 + r with q0 = x >> 12 and
   // r = (x & 0xFFF) + q0 < 2*4095, so one correction step suffices
   function automatic logic [MV_W-1:0] div_full_code(input logic [PROD_W-1:0] x);
      logic [MV_W-1:0] q0;
      logic [MV_W:0]   r;
      q0 = x[PROD_W-1:RAW_W];
      r  = {1'b0, x[RAW_W-1:0]} + {1'b0, q0};
      return (r >= {1'b0, FULL_CODE}) ? q0 + MV_W'(1) : q0;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dcsoc_ctrl.sv
// ----------------------------------------------------------------------------
// dcsoc_ctrl
// Sequencer: accept, scale, calibration update, mean, result load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcsoc_ctrl
   import dcsoc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  dcsoc_status_type      status,
   output dcsoc_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_UPDATE,
      ST_MEAN,
      ST_RESULT
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               if (status.cal_done) begin
                  state_ff <= ST_MEAN;
               end else begin
                  state_ff <= ST_RESULT;
               end
            end
            ST_MEAN: begin
               state_ff <= ST_RESULT;
            end
            ST_RESULT: begin
               if (status.out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      req_tready    = (state_ff == ST_IDLE);
      cmd.accept    = (state_ff == ST_IDLE) && req_tvalid;
      cmd.scale     = (state_ff == ST_SCALE);
      cmd.update    = (state_ff == ST_UPDATE);
      cmd.take_mean = (state_ff == ST_MEAN);
      cmd.load_out  = (state_ff == ST_RESULT) && status.out_free;
   end

endmodule

`default_nettype wire

// File: hw/rtl/dcsoc_datapath.sv
// ----------------------------------------------------------------------------
// dcsoc_datapath
// Scaling, per-channel calibration state, reciprocal multiply for the mean,
// current multiply and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcsoc_datapath
   import dcsoc_pkg::*;
#(
   parameter int CAL_SAMPLES = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  dcsoc_cmd_type           cmd,
   output dcsoc_status_type        status,
   input  wire logic [RAW_W-1:0]   raw_sample,
   input  wire logic [FS_W-1:0]    full_scale_mv,
   input  wire logic [GAIN_W-1:0]  current_gain,
   input  wire logic               rsp_tready,
   output logic                    rsp_tvalid,
   output logic                    rsp_channel,
   output logic [MV_W-1:0]         rsp_voltage_mv,
   output logic signed [CUR_W-1:0] rsp_current_ma,
   output logic                    rsp_calibrated,
   output logic                    rsp_driver_enable
);

   localparam logic [CNT_W-1:0] CAL_N = CNT_W'(CAL_SAMPLES);

   // floor(x / CAL_SAMPLES) for x < 2^ACC_W as (x * RECIP) >> RECIP_SHIFT,
   // with RECIP = ceil(2^RECIP_SHIFT / CAL_SAMPLES)
   localparam int     RECIP_SHIFT = ACC_W + $clog2(CAL_SAMPLES);
   localparam longint RECIP_FULL  =
      ((longint'(1) << RECIP_SHIFT) + longint'(CAL_SAMPLES) - longint'(1))
      / longint'(CAL_SAMPLES);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

   // item pipeline
   logic              toggle_ff;
   logic              ch_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [MV_W-1:0]   mv_ff;
   logic              enable_ff;

   // per-channel calibration state
   logic [CNT_W-1:0] cnt_ff   [2];
   logic [ACC_W-1:0] accum_ff [2];
   logic             ready_ff [2];

   // result register
   logic                    out_valid_ff;
   logic                    out_ch_ff;
   logic [MV_W-1:0]         out_mv_ff;
   logic signed [CUR_W-1:0] out_cur_ff;
   logic                    out_cal_ff;
   logic                    out_en_ff;

   logic                     sel_ready;
   logic [CNT_W-1:0]         sel_cnt;
   logic [ACC_W-1:0]         sel_accum;
   logic                     cal_open;
   logic [CNT_W-1:0]         cnt_in;
   logic [ACC_W-1:0]         accum_in;
   logic [MEAN_W-1:0]        mean_prod;
   logic [ACC_W-1:0]         mean_val;
   logic signed [DIFF_W-1:0] diff;
   logic signed [DIFF_W+GAIN_W:0] product;

   always_comb begin
      sel_ready = ready_ff[ch_ff];
      sel_cnt   = cnt_ff[ch_ff];
      sel_accum = accum_ff[ch_ff];
      cal_open  = (sel_cnt < CAL_N);
      cnt_in    = cal_open ? sel_cnt + CNT_W'(1) : sel_cnt;
      accum_in  = cal_open ? sel_accum + ACC_W'(mv_ff) : sel_accum;
      status.cal_done = (cnt_in == CAL_N) && !sel_ready;
      status.out_free = !out_valid_ff || rsp_tready;

      // sum is already in accum_ff when the mean is taken
      mean_prod = MEAN_W'(sel_accum) * MEAN_W'(RECIP);
      mean_val  = ACC_W'(mean_prod >> RECIP_SHIFT);

      diff    = $signed({1'b0, mv_ff}) - $signed({1'b0, sel_accum[MV_W-1:0]});
      product = diff * $signed({1'b0, current_gain});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         toggle_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 2; i++) begin
            cnt_ff[i]   <= '0;
            accum_ff[i] <= '0;
            ready_ff[i] <= 1'b0;
         end
      end else begin
         if (cmd.accept) begin
            toggle_ff <= ~toggle_ff;
         end
         if (cmd.update) begin
            cnt_ff[ch_ff]   <= cnt_in;
            accum_ff[ch_ff] <= accum_in;
         end
         if (cmd.take_mean) begin
            accum_ff[ch_ff] <= mean_val;
            ready_ff[ch_ff] <= 1'b1;
         end
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ch_ff   <= toggle_ff;
         prod_ff <= PROD_W'(raw_sample) * PROD_W'(full_scale_mv);
      end
      if (cmd.scale) begin
         mv_ff <= div_full_code(prod_ff);
      end
      if (cmd.update) begin
         enable_ff <= status.cal_done;
      end
      if (cmd.load_out) begin
         out_ch_ff  <= ch_ff;
         out_mv_ff  <= mv_ff;
         out_cur_ff <= sel_ready ? CUR_W'(product) : '0;
         out_cal_ff <= sel_ready;
         out_en_ff  <= enable_ff;
      end
   end

   assign rsp_tvalid        = out_valid_ff;
   assign rsp_channel       = out_ch_ff;
   assign rsp_voltage_mv    = out_mv_ff;
   assign rsp_current_ma    = out_cur_ff;
   assign rsp_calibrated    = out_cal_ff;
   assign rsp_driver_enable = out_en_ff;

endmodule

`default_nettype wire

// File: hw/rtl/dual_current_sense_offset_cal.sv
// ----------------------------------------------------------------------------
// dual_current_sense_offset_cal
// Scales alternating primary/secondary current-sense samples to millivolts,
// learns each channel's zero-current offset and reports corrected current.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one raw 12-bit converter code per item, primary channel
//    first, then alternating. An internal toggle tracks the channel.
//  - rsp_ channel: one result item per input item, in order. tuser is the
//    channel; tdata carries millivolts, current, calibrated, driver enable.
//  - csr_ port: APB-style, word 0 full scale in mV, word 1 gain in mA/mV.
//    Change only while the block is idle.
//  - Each item steps through the accept / scale / update / result sequence;
//    a new item is taken only once the sequencer is back in idle.
//  - The item that completes a channel's calibration also passes the mean
//    state: the mean is formed by a reciprocal multiply.
//  - Output register decouples the sides: a new item is accepted while the
//    previous result waits; a stalled rsp_tready holds the next result in
//    the sequencer until the output register frees up.
//  - Reset (synchronous): toggle to primary, counts, sums and calibrated
//    flags cleared, registers back to 3232 mV and gain 20. No clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dual_current_sense_offset_cal
   import dcsoc_pkg::*;
#(
   parameter int CAL_SAMPLES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [11:0] raw_sample, [15:12] zero

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [11:0] voltage_mv, [32:12] current_ma,
                                         // [33] calibrated, [34] driver_enable,
                                         // [39:35] zero
   output logic             rsp_tuser,   // [0] channel

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // configuration registers
   logic [FS_W-1:0]   full_scale_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic              csr_write;

   dcsoc_cmd_type    cmd;
   dcsoc_status_type status;

   logic                    out_channel;
   logic [MV_W-1:0]         out_voltage;
   logic signed [CUR_W-1:0] out_current;
   logic                    out_calibrated;
   logic                    out_enable;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // word address selects the register; byte offset bits are not decoded
   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= FS_RESET;
         gain_ff       <= GAIN_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_FULL_SCALE: full_scale_ff <= csr_pwdata[FS_W-1:0];
            REG_GAIN:       gain_ff       <= csr_pwdata[GAIN_W-1:0];
            default:        full_scale_ff <= full_scale_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_FULL_SCALE: csr_prdata = 32'(full_scale_ff);
         REG_GAIN:       csr_prdata = 32'(gain_ff);
         default:        csr_prdata = '0;
      endcase
   end

   dcsoc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dcsoc_datapath #(
      .CAL_SAMPLES (CAL_SAMPLES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .raw_sample        (req_tdata[RAW_W-1:0]),
      .full_scale_mv     (full_scale_ff),
      .current_gain      (gain_ff),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_channel       (out_channel),
      .rsp_voltage_mv    (out_voltage),
      .rsp_current_ma    (out_current),
      .rsp_calibrated    (out_calibrated),
      .rsp_driver_enable (out_enable)
   );

   assign rsp_tuser = out_channel;
   assign rsp_tdata = {5'b0, out_enable, out_calibrated, out_current, out_voltage};

`ifndef SYNTHESIS
   // driver enable only on a result whose channel is calibrated
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_enable) |-> out_calibrated)
      else $error("driver enable on uncalibrated result");

   // uncalibrated results carry zero current
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !out_calibrated) |-> (out_current == '0))
      else $error("nonzero current before calibration");

   // the sequencer is busy for at least the scale and update cycles
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready ##1 !req_tready)
      else $error("input accepted mid-item");
`endif

endmodule

`default_nettype wire
